FILE: hdl/sbd_pkg.sv
// Shared types and constants for the sentence boundary detector.
`timescale 1ns / 1ps

package sbd_pkg;

	// Width of the running item index; break positions wrap at 2**POS_BITS.
	localparam int POS_BITS = 16;
	// Width of the break position field on the result bus.
	localparam int POS_FIELD_BITS = 16;
	// Result bundles held between front and back.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	typedef enum logic [3:0] {
		CLS_OTHER   = 4'd0,
		CLS_CR      = 4'd1,
		CLS_LF      = 4'd2,
		CLS_EXTEND  = 4'd3,
		CLS_SEP     = 4'd4,
		CLS_FORMAT  = 4'd5,
		CLS_SP      = 4'd6,
		CLS_LOWER   = 4'd7,
		CLS_UPPER   = 4'd8,
		CLS_OLETTER = 4'd9,
		CLS_NUMERIC = 4'd10,
		CLS_ATERM   = 4'd11,
		CLS_SCONT   = 4'd12,
		CLS_STERM   = 4'd13,
		CLS_CLOSE   = 4'd14,
		CLS_NONE    = 4'd15
	} sbd_class_t;

	typedef enum logic [1:0] {
		DEC_NONE  = 2'd0,
		DEC_BREAK = 2'd1,
		DEC_PEND  = 2'd2
	} sbd_dec_t;

	typedef struct packed {
		logic [POS_FIELD_BITS-1:0] pos;
		logic                      at_end;
	} sbd_res_t;

	// One to two results caused by a single input item.
	typedef struct packed {
		logic     two;
		sbd_res_t r0;
		sbd_res_t r1;
	} sbd_bundle_t;

	function automatic logic [POS_FIELD_BITS-1:0] pos_field(input logic [POS_BITS-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return w[POS_FIELD_BITS-1:0];
	endfunction

endpackage

FILE: hdl/sentence_boundary_detector.sv
// Top level of the sentence boundary detector.
`timescale 1ns / 1ps

// Sentence boundary detector. Takes one character per item, already classed
// by its Unicode sentence-break property (s_tdata[3:0], class 15 counts as
// Other), with s_tlast marking the last character of a text. It applies
// rules SB3 to SB11, skipping Extend and Format, and sends out one result
// item per sentence break: m_tdata holds the index of the character before
// which the break lies (counted from the start of the text, wrapping at
// 2**16), m_tuser is set on the end-of-text break that follows the last
// character, and m_tlast marks the last result caused by one input item.
// No break is reported before the first character of a text. An SB8
// candidate (ATerm followed by neither a stop class nor Lower) is held open
// and reported once a stop class other than Lower arrives or the text ends;
// a Lower cancels it. One input item can cause at most two results, and
// when more would be due only the first two in order are sent. After the
// end-of-text item the block starts the next text from its reset state.
// Throughput: one input item per cycle into the classifier while the queue
// is not full; results leave at one per cycle while m_tready is high, so
// an item with two results holds the output until both are sent. A
// four-bundle queue between classifier and output stage lets the input keep
// running while the output side is stalled or catching up, until it fills.
module sentence_boundary_detector
	import sbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] break_class, [7:4] zero
	input  logic        s_tlast,   // final_item
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] break_position
	output logic        m_tuser,   // at_text_end
	output logic        m_tlast    // last_of_run
);

	sbd_bundle_t fe_bundle, q_head;
	logic        fe_push, q_full, q_nonempty, be_pop;

	// classifier: decision logic plus sequence state
	sbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_class (s_tdata[3:0]),
		.in_final (s_tlast),
		.q_full   (q_full),
		.in_ready (s_tready),
		.push     (fe_push),
		.bundle   (fe_bundle)
	);

	// decouples classifier from the output stall
	sbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fe_push),
		.push_data (fe_bundle),
		.pop       (be_pop),
		.head      (q_head),
		.nonempty  (q_nonempty),
		.full      (q_full)
	);

	// output register, one result item per handshake
	sbd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.q_nonempty (q_nonempty),
		.pop        (be_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

FILE: hdl/sbd_front.sv
// Front end: classifies each item against rules SB3-SB11 and builds result bundles.
`timescale 1ns / 1ps

module sbd_front
	import sbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [3:0]  in_class,
	input  logic        in_final,
	input  logic        q_full,
	output logic        in_ready,
	output logic        push,
	output sbd_bundle_t bundle
);

	sbd_class_t          prev_q, older_q, newer_q;
	logic [1:0]          alvl_q;
	logic [2:0]          slvl_q;
	logic                pend_q;
	logic [POS_BITS-1:0] pend_pos_q;
	logic [POS_BITS-1:0] idx_q;

	sbd_class_t          c;
	sbd_dec_t            dec;
	logic                sb8_open, a13, s13, accept;
	logic                confirm, pend_nx;
	logic [POS_BITS-1:0] pend_pos_nx, idx_inc;
	logic [1:0]          alvl_nx;
	logic [2:0]          slvl_nx;
	logic [3:0]          ev_v, ev_end;
	logic [POS_BITS-1:0] ev_pos [4];
	logic [1:0]          n;

	function automatic logic is_parasep(input sbd_class_t k);
		return k inside {CLS_SEP, CLS_CR, CLS_LF};
	endfunction

	function automatic logic is_stop(input sbd_class_t k);
		return is_parasep(k) || (k inside {CLS_OLETTER, CLS_UPPER, CLS_LOWER,
			CLS_STERM, CLS_ATERM});
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign c        = (in_class == 4'(CLS_NONE)) ? CLS_OTHER : sbd_class_t'(in_class);
	assign a13      = (alvl_q != 2'd0);
	assign s13      = (slvl_q >= 3'd1) && (slvl_q <= 3'd3);
	assign idx_inc  = idx_q + POS_BITS'(1);

	// Break decision for the boundary before the current item.
	always_comb begin
		dec = DEC_NONE;
		sb8_open = 1'b0;
		if (prev_q == CLS_NONE) begin
			dec = DEC_NONE;
		end else if (prev_q == CLS_CR && c == CLS_LF) begin
			dec = DEC_NONE;
		end else if (is_parasep(prev_q)) begin
			dec = DEC_BREAK;
		end else if (c == CLS_EXTEND || c == CLS_FORMAT) begin
			dec = DEC_NONE;
		end else if (newer_q == CLS_ATERM && c == CLS_NUMERIC) begin
			dec = DEC_NONE;
		end else if ((older_q == CLS_UPPER || older_q == CLS_LOWER) &&
				newer_q == CLS_ATERM && c == CLS_UPPER) begin
			dec = DEC_NONE;
		end else if (a13 && c == CLS_LOWER) begin
			dec = DEC_NONE;
		end else begin
			sb8_open = a13 && !is_stop(c);
			if (s13 && (c inside {CLS_SCONT, CLS_STERM, CLS_ATERM})) begin
				dec = DEC_NONE;
			end else if ((slvl_q == 3'd1 || slvl_q == 3'd2) &&
					(c == CLS_CLOSE || c == CLS_SP || is_parasep(c))) begin
				dec = DEC_NONE;
			end else if (s13 && (c == CLS_SP || is_parasep(c))) begin
				dec = DEC_NONE;
			end else if (slvl_q >= 3'd1 && slvl_q <= 3'd4) begin
				dec = sb8_open ? DEC_PEND : DEC_BREAK;
			end
		end
	end

	// Sequence levels after this item (Extend and Format leave them alone).
	always_comb begin
		if (c == CLS_ATERM)
			alvl_nx = 2'd1;
		else if ((alvl_q == 2'd1 || alvl_q == 2'd2) && c == CLS_CLOSE)
			alvl_nx = 2'd2;
		else if (a13 && c == CLS_SP)
			alvl_nx = 2'd3;
		else
			alvl_nx = 2'd0;

		if (c == CLS_ATERM || c == CLS_STERM)
			slvl_nx = 3'd1;
		else if ((slvl_q == 3'd1 || slvl_q == 3'd2) && c == CLS_CLOSE)
			slvl_nx = 3'd2;
		else if (s13 && c == CLS_SP)
			slvl_nx = 3'd3;
		else if (s13 && is_parasep(c))
			slvl_nx = 3'd4;
		else
			slvl_nx = 3'd0;
	end

	// Candidate results in output order; only the first two are kept.
	always_comb begin
		confirm     = pend_q && is_stop(c) && c != CLS_LOWER;
		pend_nx     = (pend_q && !is_stop(c)) || dec == DEC_PEND;
		pend_pos_nx = (dec == DEC_PEND) ? idx_q : pend_pos_q;

		ev_v      = {in_final, in_final && pend_nx, dec == DEC_BREAK, confirm};
		ev_end    = 4'b1000;
		ev_pos[0] = pend_pos_q;
		ev_pos[1] = idx_q;
		ev_pos[2] = pend_pos_nx;
		ev_pos[3] = idx_inc;

		n = 2'd0;
		bundle = '0;
		for (int i = 0; i < 4; i++) begin
			if (ev_v[i] && n == 2'd0) begin
				bundle.r0.pos    = pos_field(ev_pos[i]);
				bundle.r0.at_end = ev_end[i];
				n = 2'd1;
			end else if (ev_v[i] && n == 2'd1) begin
				bundle.r1.pos    = pos_field(ev_pos[i]);
				bundle.r1.at_end = ev_end[i];
				n = 2'd2;
			end
		end
		bundle.two = (n == 2'd2);
		push = accept && (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= CLS_NONE;
			older_q    <= CLS_NONE;
			newer_q    <= CLS_NONE;
			alvl_q     <= '0;
			slvl_q     <= '0;
			pend_q     <= 1'b0;
			pend_pos_q <= '0;
			idx_q      <= '0;
		end else if (accept) begin
			if (in_final) begin
				// end of text: start the next text from reset state
				prev_q     <= CLS_NONE;
				older_q    <= CLS_NONE;
				newer_q    <= CLS_NONE;
				alvl_q     <= '0;
				slvl_q     <= '0;
				pend_q     <= 1'b0;
				pend_pos_q <= '0;
				idx_q      <= '0;
			end else begin
				prev_q     <= c;
				pend_q     <= pend_nx;
				pend_pos_q <= pend_pos_nx;
				idx_q      <= idx_inc;
				if (c != CLS_EXTEND && c != CLS_FORMAT) begin
					older_q <= newer_q;
					newer_q <= c;
					alvl_q  <= alvl_nx;
					slvl_q  <= slvl_nx;
				end
			end
		end
	end

endmodule

FILE: hdl/sbd_queue.sv
// Small FIFO of result bundles between front and back.
`timescale 1ns / 1ps

module sbd_queue
	import sbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  sbd_bundle_t push_data,
	input  logic        pop,
	output sbd_bundle_t head,
	output logic        nonempty,
	output logic        full
);

	sbd_bundle_t     mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_push, do_pop;

	assign nonempty = (cnt_q != '0);
	assign full     = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign head     = mem_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + Q_AW'(1);
			if (do_pop)
				rd_q <= rd_q + Q_AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (Q_AW+1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (Q_AW+1)'(1);
		end
	end

endmodule

FILE: hdl/sbd_back.sv
// Back end: output register that sends each bundle out one result item at a time.
`timescale 1ns / 1ps

module sbd_back
	import sbd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  sbd_bundle_t               head,
	input  logic                      q_nonempty,
	output logic                      pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [POS_FIELD_BITS-1:0] m_tdata,
	output logic                      m_tuser,
	output logic                      m_tlast
);

	logic     cur_valid_q, cur_two_q;
	sbd_res_t r0_q, r1_q;
	logic     adv;

	assign m_tvalid = cur_valid_q;
	assign m_tdata  = r0_q.pos;
	assign m_tuser  = r0_q.at_end;
	assign m_tlast  = !cur_two_q;
	assign adv      = cur_valid_q && m_tready;
	assign pop      = q_nonempty && (!cur_valid_q || (adv && !cur_two_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_two_q   <= 1'b0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			cur_two_q   <= head.two;
		end else if (adv) begin
			if (cur_two_q)
				cur_two_q <= 1'b0;
			else
				cur_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			r0_q <= head.r0;
			r1_q <= head.r1;
		end else if (adv && cur_two_q) begin
			r0_q <= r1_q;
		end
	end

endmodule
